/* rtl/core/bounded_positional_list_defines.svh */
// Assertion macros for the bounded positional list block.
// Depends on nothing; included by modules that carry assertions.
`ifndef BOUNDED_POSITIONAL_LIST_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define BPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/bpl_pkg.sv */
// Shared types and constants for the bounded positional list.
// No dependencies.
package bpl_pkg;
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    REQ_PUSH_FRONT = 4'd0, REQ_PUSH_BACK = 4'd1, REQ_INSERT = 4'd2,
    REQ_POP_FRONT = 4'd3, REQ_POP_BACK = 4'd4, REQ_REMOVE_POS = 4'd5,
    REQ_REMOVE_VAL = 4'd6, REQ_FRONT = 4'd7, REQ_BACK = 4'd8,
    REQ_READ_POS = 4'd9, REQ_FIND = 4'd10
  } req_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_FULL = 3'd1, ST_EMPTY = 3'd2, ST_BAD_POS = 3'd3,
    ST_NOT_FOUND = 3'd4, ST_BAD_REQ = 3'd5
  } status_t;

  // queued request from front end to back end
  typedef struct packed {
    logic [3:0]            req;
    logic [31:0]           value;
    logic [4:0]            position;
  } cmd_t;
endpackage

/* rtl/core/bpl_front.sv */
// Front end: a two-entry command queue that registers the input.
// Depends on bpl_pkg.
module bpl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [3:0]     in_req_type,
  input  logic [31:0]    in_value,
  input  logic [4:0]     in_position,
  output logic           cmd_valid,
  input  logic           cmd_take,
  output bpl_pkg::cmd_t  cmd
);
  import bpl_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;
  logic       push, pop;

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill_r != 2'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q_r[rp_r];

  // hold queued transactions
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{req: in_req_type, value: in_value, position: in_position};
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

  `include "bounded_positional_list_defines.svh"
  `BPL_ASSERT_IMP(a_no_overflow, fill_r == 2'd2, !push || pop)
  `BPL_ASSERT_IMP(a_fill_range, 1'b1, fill_r != 2'd3)
  `BPL_ASSERT_IMP(a_no_underflow, fill_r == 2'd0, !pop)
endmodule

/* rtl/core/bpl_back.sv */
// Back end: shift-register list with parallel compare and output register.
// Depends on bpl_pkg.
module bpl_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [4:0]              max_length,
  input  logic                    cmd_valid,
  output logic                    cmd_take,
  input  bpl_pkg::cmd_t           cmd,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_result_value,
  output logic [4:0]              out_result_position,
  output logic [4:0]              out_element_count
);
  import bpl_pkg::*;

  logic [DATA_WIDTH-1:0] ent_r [CAPACITY];
  logic [DATA_WIDTH-1:0] ent_nxt [CAPACITY];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  ov_r;
  logic [2:0]            st_r, st_nxt;
  logic [31:0]           rv_r, rv_nxt;
  logic [4:0]            rp_r, rp_nxt;
  logic [CAPACITY-1:0]   hit;
  logic                  any_hit;
  logic [IDX_W-1:0]      hit_idx;
  logic [CNT_W-1:0]      limit;
  logic                  full;
  logic [5:0]            pos6, cnt6;
  logic [IDX_W-1:0]      pidx, last;
  logic [DATA_WIDTH-1:0] v;

  assign cmd_take = cmd_valid && (!ov_r || !out_stall);
  assign v        = cmd.value[DATA_WIDTH-1:0];
  assign limit    = (max_length > 5'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(max_length);
  assign full     = cnt_r >= limit;
  assign pos6     = 6'(cmd.position);
  assign cnt6     = 6'(cnt_r);
  assign pidx     = IDX_W'(cmd.position - 5'd1);
  assign last     = IDX_W'(cnt_r - CNT_W'(1));

  // compare all live entries, pick first match
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++)
      hit[i] = (CNT_W'(i) < cnt_r) && (ent_r[i] == v);
    for (int i = CAPACITY-1; i >= 0; i--)
      if (hit[i]) begin any_hit = 1'b1; hit_idx = IDX_W'(i); end
  end

  function automatic logic [31:0] wid(input logic [DATA_WIDTH-1:0] w);
    return 32'(signed'(w));
  endfunction

  // decode and execute one command
  always_comb begin
    logic             do_open, do_close;
    logic [IDX_W-1:0] at;
    ent_nxt = ent_r; cnt_nxt = cnt_r;
    st_nxt = ST_OK; rv_nxt = '0; rp_nxt = '0;
    do_open = 1'b0; do_close = 1'b0; at = '0;
    case (cmd.req)
      REQ_PUSH_FRONT: if (full) st_nxt = ST_FULL; else begin do_open = 1'b1; at = '0; end
      REQ_PUSH_BACK:  if (full) st_nxt = ST_FULL;
                      else begin do_open = 1'b1; at = IDX_W'(cnt_r); end
      REQ_INSERT: begin
        if (pos6 == 6'd0 || pos6 > cnt6 + 6'd1) st_nxt = ST_BAD_POS;
        else if (full) st_nxt = ST_FULL;
        else begin do_open = 1'b1; at = pidx; end
      end
      REQ_POP_FRONT, REQ_FRONT: begin
        if (cnt_r == '0) st_nxt = ST_EMPTY;
        else begin rv_nxt = wid(ent_r[0]); do_close = (cmd.req == REQ_POP_FRONT); at = '0; end
      end
      REQ_POP_BACK, REQ_BACK: begin
        if (cnt_r == '0) st_nxt = ST_EMPTY;
        else begin rv_nxt = wid(ent_r[last]); do_close = (cmd.req == REQ_POP_BACK); at = last; end
      end
      REQ_REMOVE_POS: begin
        if (cnt_r == '0) st_nxt = ST_EMPTY;
        else if (pos6 == 6'd0 || pos6 > cnt6) st_nxt = ST_BAD_POS;
        else begin rv_nxt = wid(ent_r[pidx]); do_close = 1'b1; at = pidx; end
      end
      REQ_REMOVE_VAL: begin
        if (cnt_r == '0) st_nxt = ST_EMPTY;
        else if (any_hit) begin rv_nxt = wid(ent_r[hit_idx]); do_close = 1'b1; at = hit_idx; end
      end
      REQ_READ_POS: begin
        if (pos6 == 6'd0 || pos6 > cnt6) st_nxt = ST_BAD_POS;
        else rv_nxt = wid(ent_r[pidx]);
      end
      REQ_FIND: begin
        if (any_hit) rp_nxt = 5'(hit_idx) + 5'd1;
        else st_nxt = ST_NOT_FOUND;
      end
      default: st_nxt = ST_BAD_REQ;
    endcase
    // shift entries to open or close a gap
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_open) begin
        if (IDX_W'(i) == at) ent_nxt[i] = v;
        else if (IDX_W'(i) > at && i > 0) ent_nxt[i] = ent_r[i-1];
      end else if (do_close) begin
        if (IDX_W'(i) >= at && i < CAPACITY-1) ent_nxt[i] = ent_r[i+1];
      end
    end
    if (do_open)  cnt_nxt = cnt_r + CNT_W'(1);
    if (do_close) cnt_nxt = cnt_r - CNT_W'(1);
  end

  // commit list state and result
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      ent_r <= ent_nxt; st_r <= st_nxt; rv_r <= rv_nxt; rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cmd_take) cnt_r <= cnt_nxt;
      if (cmd_take) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  assign out_valid           = ov_r;
  assign out_status          = st_r;
  assign out_result_value    = signed'(rv_r);
  assign out_result_position = rp_r;
  assign out_element_count   = 5'(cnt_r);

  `include "bounded_positional_list_defines.svh"
  `BPL_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(CAPACITY))
  `BPL_ASSERT_NEXT(a_cnt_hold, !cmd_take, $stable(cnt_r))
  `BPL_ASSERT_NEXT(a_take_valid, cmd_take, out_valid)
endmodule

/* rtl/core/bounded_positional_list.sv */
// Bounded positional list: up to 16 signed words kept in order.
// Path: the input is written into the command queue, then executed into the output register.
// Throughput: one transaction per cycle while the output is not stalled.
// Set by the parallel shift/compare in the back end.
// Reset: synchronous active-low rst_n empties the list, sets max_length to 16.
// Top level; depends on bpl_pkg, bpl_front, bpl_back.
module bounded_positional_list (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_max_length,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_req_type,
  input  logic signed [31:0] in_value,
  input  logic [4:0]         in_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_result_value,
  output logic [4:0]         out_result_position,
  output logic [4:0]         out_element_count
);
  import bpl_pkg::*;

  logic [4:0] max_len_r;
  logic       cmd_valid, cmd_take;
  cmd_t       cmd;

  assign cfg_ready = 1'b1;

  // hold the length limit
  always_ff @(posedge clk) begin
    if (!rst_n) max_len_r <= 5'd16;
    else if (cfg_valid) max_len_r <= cfg_max_length;
  end

  bpl_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type,
    .in_value(unsigned'(in_value)), .in_position,
    .cmd_valid, .cmd_take, .cmd
  );

  bpl_back u_back (
    .clk, .rst_n, .max_length(max_len_r), .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_status, .out_result_value,
    .out_result_position, .out_element_count
  );
endmodule
